@@ rtl/clb_pkg.sv @@
// Package for the circular log buffer: action codes, fixed field widths and
// the result record passed from the control core to the output stage.
// No dependencies.
`default_nettype none

package clb_pkg;

  localparam int ACTION_W = 3;
  localparam int DATA_W   = 64;
  localparam int LIMIT_W  = 9;
  localparam int IDX_W    = 8;

  localparam logic [ACTION_W-1:0] ACT_APPEND     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_OPEN_NEWEST = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_OPEN_UNNOT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_NEXT       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic [IDX_W-1:0]  entry_count;
    logic [IDX_W-1:0]  head_index;
    logic [IDX_W-1:0]  tail_index;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/clb_if.sv @@
// Valid/ready channel interfaces for the log buffer's request and result
// streams. Depends on clb_pkg.
`default_nettype none

interface clb_in_if import clb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   entry_data;
  logic [LIMIT_W-1:0]  max_results;

  modport source (output valid, action, entry_data, max_results, input ready);
  modport sink   (input valid, action, entry_data, max_results, output ready);
endinterface

interface clb_out_if import clb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              read_valid;
  logic [IDX_W-1:0]  entry_count;
  logic [IDX_W-1:0]  head_index;
  logic [IDX_W-1:0]  tail_index;

  modport source (output valid, read_data, read_valid, entry_count, head_index,
                  tail_index, input ready);
  modport sink   (input valid, read_data, read_valid, entry_count, head_index,
                  tail_index, output ready);
endinterface

`default_nettype wire

@@ rtl/clb_out_reg.sv @@
// Output register for the log buffer's result stream.
// Holds one result record until the receiver takes it. Depends on clb_pkg.
`default_nettype none

module clb_out_reg import clb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  wire res_t res,
  output logic      free,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // Slot is usable if empty or emptied by a transfer this cycle.
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (res_valid) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/clb_ctrl.sv @@
// Control core of the log buffer: entry memory, ring pointers, reader state
// and the sequencer for append, read, and clearing sweeps. Depends on clb_pkg.
`default_nettype none

module clb_ctrl import clb_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int ENTRY_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [DATA_W-1:0]   entry_data,
  input  wire logic [LIMIT_W-1:0]  max_results,
  input  wire logic                out_free,
  output logic                     res_valid,
  output res_t                     res
);

  localparam int AW = $clog2(DEPTH);
  localparam int GW = (AW > LIMIT_W) ? AW : LIMIT_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] mark_r, mark_nxt;
  logic          rd_open_r, rd_open_nxt;
  logic          rd_newest_r, rd_newest_nxt;
  logic [AW-1:0] rd_slot_r, rd_slot_nxt;
  logic [AW-1:0] rd_done_r, rd_done_nxt;
  logic [AW-1:0] rd_goal_r, rd_goal_nxt;

  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [ENTRY_BITS-1:0] rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;

  logic          accept;
  logic [AW-1:0] cur_count;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] unnot_goal;
  logic [GW-1:0] lim_w;
  logic [GW-1:0] cnt_w;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] count_of(input logic [AW-1:0] h,
                                             input logic [AW-1:0] t);
    logic [AW:0] d;
    d = {1'b0, h} - {1'b0, t} + ((h < t) ? DEPTH_W : '0);
    count_of = d[AW-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [AW-1:0] v);
    logic [AW+IDX_W-1:0] w;
    w = (AW+IDX_W)'(v);
    to_idx = w[IDX_W-1:0];
  endfunction

  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cur_count = count_of(head_r, tail_r);
  assign head_inc  = ptr_inc(head_r);
  assign lim_w     = GW'(max_results);
  assign cnt_w     = GW'(cur_count);

  // Distance from the slot after the mark up to head, modulo DEPTH.
  always_comb begin
    logic [AW:0] d;
    d = {1'b0, head_r} - {1'b0, mark_r} - (AW+1)'(1)
        + ((head_r > mark_r) ? '0 : DEPTH_W);
    unnot_goal = d[AW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    mark_nxt      = mark_r;
    rd_open_nxt   = rd_open_r;
    rd_newest_nxt = rd_newest_r;
    rd_slot_nxt   = rd_slot_r;
    rd_done_nxt   = rd_done_r;
    rd_goal_nxt   = rd_goal_r;
    mem_we        = 1'b0;
    mem_waddr     = head_r;
    mem_wdata     = '0;
    mem_raddr     = rd_slot_r;
    res_valid     = 1'b0;
    res.read_data = '0;
    res.read_valid = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST) begin
          clr_idx_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_APPEND: begin
              mem_we      = 1'b1;
              mem_wdata   = entry_data[ENTRY_BITS-1:0];
              head_nxt    = head_inc;
              if (head_inc == tail_r) begin
                tail_nxt = ptr_inc(tail_r);
              end
              rd_open_nxt = 1'b0;
              state_nxt   = ST_ZERO;
            end
            ACT_OPEN_NEWEST: begin
              rd_goal_nxt   = (lim_w == '0 || lim_w > cnt_w) ? cur_count
                                                             : lim_w[AW-1:0];
              rd_done_nxt   = '0;
              rd_slot_nxt   = ptr_dec(head_r);
              rd_newest_nxt = 1'b1;
              rd_open_nxt   = 1'b1;
              res_valid     = 1'b1;
            end
            ACT_OPEN_UNNOT: begin
              rd_goal_nxt   = unnot_goal;
              rd_done_nxt   = '0;
              rd_slot_nxt   = ptr_inc(mark_r);
              rd_newest_nxt = 1'b0;
              rd_open_nxt   = 1'b1;
              res_valid     = 1'b1;
            end
            ACT_NEXT: begin
              if (rd_open_r && rd_done_r < rd_goal_r) begin
                rd_done_nxt = rd_done_r + 1'b1;
                if (rd_newest_r) begin
                  rd_slot_nxt = ptr_dec(rd_slot_r);
                end else begin
                  mark_nxt    = rd_slot_r;
                  rd_slot_nxt = ptr_inc(rd_slot_r);
                end
                state_nxt = ST_READ;
              end else begin
                res_valid = 1'b1;
              end
            end
            ACT_CLEAR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              mark_nxt      = LAST;
              rd_open_nxt   = 1'b0;
              rd_newest_nxt = 1'b0;
              rd_slot_nxt   = '0;
              rd_done_nxt   = '0;
              rd_goal_nxt   = '0;
              clr_idx_nxt   = '0;
              res_valid     = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_ZERO: begin
        // Slot under the advanced head is blanked.
        mem_we    = 1'b1;
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        res.read_data  = DATA_W'(rdata_r);
        res.read_valid = 1'b1;
        res_valid      = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.entry_count = to_idx(count_of(head_nxt, tail_nxt));
    res.head_index  = to_idx(head_nxt);
    res.tail_index  = to_idx(tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      mark_r      <= LAST;
      rd_open_r   <= 1'b0;
      rd_newest_r <= 1'b0;
      rd_slot_r   <= '0;
      rd_done_r   <= '0;
      rd_goal_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      mark_r      <= mark_nxt;
      rd_open_r   <= rd_open_nxt;
      rd_newest_r <= rd_newest_nxt;
      rd_slot_r   <= rd_slot_nxt;
      rd_done_r   <= rd_done_nxt;
      rd_goal_r   <= rd_goal_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/circular_log_buffer_with_readers.sv @@
// Circular log buffer with newest-first and unnotified readers.
// Channels: in_ch carries action, entry_data and max_results; out_ch returns
// one result per request: read_data/read_valid for a next request, plus the
// entry count and head/tail slots after the request.
// Steps per request: open reader, failed next, clear and unused codes give
// their result on acceptance; append writes the entry, then blanks the new
// head slot on the single memory write port; a delivering next does a
// synchronous memory read, then returns the data. Result is registered: it
// appears the cycle after the request finishes.
// Clear returns its result at once, then sweeps all DEPTH slots to zero, one
// per cycle, and takes no request until the sweep ends.
// Reset: synchronous, active low; afterwards the same sweep runs before the
// first request is taken.
// A stalled receiver holds the result in the output register; one more
// request is taken in the cycle the held result transfers.
// Depends on clb_pkg, clb_if, clb_ctrl and clb_out_reg.
`default_nettype none

module circular_log_buffer_with_readers import clb_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int ENTRY_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  clb_in_if.sink    in_ch,
  clb_out_if.source out_ch
);

  logic out_free;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic out_valid;

  clb_ctrl #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .action      (in_ch.action),
    .entry_data  (in_ch.entry_data),
    .max_results (in_ch.max_results),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  clb_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.read_data   = out_res.read_data;
  assign out_ch.read_valid  = out_res.read_valid;
  assign out_ch.entry_count = out_res.entry_count;
  assign out_ch.head_index  = out_res.head_index;
  assign out_ch.tail_index  = out_res.tail_index;

endmodule

`default_nettype wire

@@ dv/circular_log_buffer_with_readers_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for circular_log_buffer_with_readers: directed and random
// request streams, each result checked against a software copy of the ring log.
// Depends on clb_pkg, clb_if and the block's RTL.

module circular_log_buffer_with_readers_tb;
  import clb_pkg::*;

  localparam int DEPTH        = 256;
  localparam int ENTRY_BITS   = 64;
  localparam int ACT_TOP      = (1 << ACTION_W) - 1;  // highest encodable action
  localparam int RAND_ITEMS   = 1550;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - ENTRY_BITS);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   entry_data;
    logic [LIMIT_W-1:0]  max_results;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  clb_in_if  in_ch ();
  clb_out_if out_ch ();

  circular_log_buffer_with_readers #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring log copy
  logic [DATA_W-1:0]  log_mem [DEPTH];
  logic [IDX_W-1:0]   head_q, tail_q, mark_q, rd_slot;
  logic               rd_open, rd_newest;
  logic [LIMIT_W-1:0] rd_done, rd_goal;

  req_t req_queue[$];
  res_t ring_results_due[$];
  res_t want;
  req_t cur;

  int total_items, rand_count, taken_count, checked_count, err_count;
  int read_hits, drop_count, clear_count, cycle_count;
  int tx_idle_pct, rx_idle_pct;
  logic req_taken = 1'b0;

  function automatic void log_clear();
    foreach (log_mem[i]) log_mem[i] = '0;
    head_q    = '0;
    tail_q    = '0;
    mark_q    = IDX_W'(DEPTH - 1);
    rd_open   = 1'b0;
    rd_newest = 1'b0;
    rd_slot   = '0;
    rd_done   = '0;
    rd_goal   = '0;
  endfunction

  function automatic logic [LIMIT_W-1:0] held_entries();
    logic [IDX_W-1:0] d;
    d = head_q - tail_q;
    return LIMIT_W'(d);
  endfunction

  // Applies one request to the log copy and returns the result it must produce.
  function automatic res_t log_step(req_t r);
    res_t res;
    logic [LIMIT_W-1:0] n;
    logic [IDX_W-1:0] gap;
    res = '0;
    case (r.action)
      ACT_APPEND: begin
        log_mem[head_q] = r.entry_data & ENTRY_MASK;
        head_q = head_q + 1'b1;
        if (head_q == tail_q) begin
          tail_q = tail_q + 1'b1;
          drop_count++;
        end
        log_mem[head_q] = '0;
        rd_open = 1'b0;
      end
      ACT_OPEN_NEWEST: begin
        n = held_entries();
        rd_goal   = (r.max_results == '0 || r.max_results > n) ? n : r.max_results;
        rd_done   = '0;
        rd_slot   = head_q - 1'b1;
        rd_newest = 1'b1;
        rd_open   = 1'b1;
      end
      ACT_OPEN_UNNOT: begin
        // goal ignores tail: an overrun mark reads stale or blanked slots
        gap       = head_q - mark_q - 1'b1;
        rd_goal   = LIMIT_W'(gap);
        rd_done   = '0;
        rd_slot   = mark_q + 1'b1;
        rd_newest = 1'b0;
        rd_open   = 1'b1;
      end
      ACT_NEXT: begin
        if (rd_open && rd_done < rd_goal) begin
          res.read_data  = log_mem[rd_slot];
          res.read_valid = 1'b1;
          rd_done++;
          read_hits++;
          if (rd_newest) begin
            rd_slot = rd_slot - 1'b1;
          end else begin
            mark_q  = rd_slot;
            rd_slot = rd_slot + 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        log_clear();
        clear_count++;
      end
      default: ;
    endcase
    res.entry_count = IDX_W'(held_entries());
    res.head_index  = head_q;
    res.tail_index  = tail_q;
    return res;
  endfunction

  task automatic add_req(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] data,
                         input logic [LIMIT_W-1:0] lim);
    req_t r;
    r.action      = act;
    r.entry_data  = data;
    r.max_results = lim;
    req_queue.push_back(r);
    if (act <= ACT_CLEAR) rand_count++;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    return LIMIT_W'($urandom_range(0, (1 << LIMIT_W) - 1));
  endfunction

  function automatic logic [LIMIT_W-1:0] newest_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return LIMIT_W'($urandom_range(1, 8));
      2: return rand_limit();
      default: return LIMIT_W'(DEPTH);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
      err_count++;
    end
  endtask

  // Monitor: outputs first, then the request transfer of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        checked_count++;
        if (ring_results_due.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual data=%h vld=%b",
                   $time, out_ch.read_data, out_ch.read_valid);
          err_count++;
        end else begin
          want = ring_results_due.pop_front();
          check_field("read_data", want.read_data, out_ch.read_data);
          check_field("read_valid", DATA_W'(want.read_valid), DATA_W'(out_ch.read_valid));
          check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(out_ch.entry_count));
          check_field("head_index", DATA_W'(want.head_index), DATA_W'(out_ch.head_index));
          check_field("tail_index", DATA_W'(want.tail_index), DATA_W'(out_ch.tail_index));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cur.action      = in_ch.action;
        cur.entry_data  = in_ch.entry_data;
        cur.max_results = in_ch.max_results;
        ring_results_due.push_back(log_step(cur));
        taken_count++;
      end
      req_taken <= in_ch.valid && in_ch.ready;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Driver and receiver back-pressure, both on the falling edge
  always @(negedge clk) begin
    if (taken_count < total_items / 3) begin
      tx_idle_pct = 7;
      rx_idle_pct = 72;
    end else if (taken_count < 2 * total_items / 3) begin
      tx_idle_pct = 72;
      rx_idle_pct = 7;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      if (req_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.action      <= req_queue[0].action;
        in_ch.entry_data  <= req_queue[0].entry_data;
        in_ch.max_results <= req_queue[0].max_results;
        void'(req_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d requests taken, %0d results outstanding",
               $time, taken_count, total_items, ring_results_due.size());
      $display("** circular_log_buffer_with_readers: FAILED **");
      $finish;
    end
  end

  initial begin
    int pick;
    int len;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_APPEND;
    in_ch.entry_data  = '0;
    in_ch.max_results = '0;
    out_ch.ready      = 1'b0;
    cycle_count       = 0;
    log_clear();

    // Directed: empty-ring reads, limits, replacement, cancel, unused codes, clear
    add_req(ACT_NEXT, '0, '0);
    add_req(ACT_OPEN_UNNOT, '0, '0);
    add_req(ACT_NEXT, '1, '1);
    add_req(ACT_APPEND, '1, '0);
    add_req(ACT_APPEND, '0, '1);
    add_req(ACT_APPEND, rand_word(), '0);
    add_req(ACT_APPEND, {$urandom, $urandom}, '0);
    add_req(ACT_OPEN_NEWEST, '0, '0);
    repeat (5) add_req(ACT_NEXT, '0, '0);
    add_req(ACT_OPEN_NEWEST, '0, LIMIT_W'(2));
    add_req(ACT_NEXT, '0, '0);
    add_req(ACT_OPEN_NEWEST, '0, '1);
    add_req(ACT_NEXT, '0, '0);
    add_req(ACT_OPEN_UNNOT, '0, '0);
    repeat (2) add_req(ACT_NEXT, '0, '0);
    add_req(ACT_APPEND, rand_word(), '0);
    add_req(ACT_NEXT, '0, '0);
    for (int c = ACT_CLEAR + 1; c <= ACT_TOP; c++) add_req(ACTION_W'(c), '1, '1);
    add_req(ACT_CLEAR, '0, '0);
    add_req(ACT_OPEN_NEWEST, '0, LIMIT_W'(DEPTH));
    add_req(ACT_NEXT, '0, '0);

    // Random: mostly well-formed reader sessions and append bursts, some noise
    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 320) : $urandom_range(1, 24);
        repeat (len) add_req(ACT_APPEND, rand_word(), rand_limit());
      end else if (pick < 55) begin
        add_req(ACT_OPEN_NEWEST, rand_word(), newest_limit());
        repeat ($urandom_range(0, 24)) add_req(ACT_NEXT, rand_word(), rand_limit());
      end else if (pick < 73) begin
        add_req(ACT_OPEN_UNNOT, rand_word(), rand_limit());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 270) : $urandom_range(0, 24);
        repeat (len) add_req(ACT_NEXT, rand_word(), rand_limit());
      end else if (pick < 85) begin
        // reader cut short by appends
        add_req($urandom_range(0, 1) ? ACT_OPEN_NEWEST : ACT_OPEN_UNNOT, rand_word(),
                newest_limit());
        repeat ($urandom_range(1, 4)) add_req(ACT_NEXT, rand_word(), rand_limit());
        repeat ($urandom_range(1, 3)) add_req(ACT_APPEND, rand_word(), rand_limit());
        repeat ($urandom_range(1, 3)) add_req(ACT_NEXT, rand_word(), rand_limit());
      end else if (pick < 99) begin
        repeat ($urandom_range(1, 6))
          add_req(ACTION_W'($urandom_range(0, ACT_TOP)), rand_word(), rand_limit());
      end else begin
        add_req(ACT_CLEAR, rand_word(), rand_limit());
      end
    end
    total_items = req_queue.size();

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (taken_count < total_items) @(posedge clk);
    while (ring_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests, %0d results checked: %0d entries read back,", total_items,
             checked_count, read_hits);
    $display("%0d oldest entries dropped on a full ring, %0d clears, %0d errors.", drop_count,
             clear_count, err_count);
    if (err_count == 0) begin
      $display("** circular_log_buffer_with_readers: PASSED **");
    end else begin
      $display("** circular_log_buffer_with_readers: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/clb_pkg.sv
rtl/clb_if.sv
rtl/clb_out_reg.sv
rtl/clb_ctrl.sv
rtl/circular_log_buffer_with_readers.sv
dv/circular_log_buffer_with_readers_tb.sv
